// ===== rtl/cofs_pkg.sv =====
// Shared types, constants and helpers of the clock offset minimum filter.
`default_nettype none

package cofs_pkg;

    // Field widths
    localparam int FUNC_W   = 2;
    localparam int TYPE_W   = 8;
    localparam int IDENT_W  = 16;
    localparam int MS_W     = 27;
    localparam int REMOTE_W = 32;
    localparam int STATUS_W = 3;
    localparam int OFFSET_W = 27;
    localparam int COUNT_W  = 8;
    localparam int DELTA_W  = 32;
    localparam int WIDE_W   = 33;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_CHECK_RANGE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_ROUND_TRIP_LIM = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SAMPLES_NEEDED = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_RETRY_LIMIT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_LOCAL_IDENT    = 3'd4;

    // Register reset values
    localparam logic              CHECK_RANGE_RST    = 1'b1;
    localparam logic [MS_W-1:0]   ROUND_TRIP_LIM_RST = 27'd20;
    localparam logic [COUNT_W-1:0] SAMPLES_NEEDED_RST = 8'd5;
    localparam logic [COUNT_W-1:0] RETRY_LIMIT_RST    = 8'd10;
    localparam logic [IDENT_W-1:0] LOCAL_IDENT_RST    = 16'd0;

    // Protocol and arithmetic constants
    localparam logic [TYPE_W-1:0]         TS_REPLY  = 8'd14;
    localparam logic signed [WIDE_W-1:0]  WRAP_HIGH = 33'sd43199999;
    localparam logic signed [WIDE_W-1:0]  WRAP_LOW  = -33'sd43200000;
    localparam logic signed [WIDE_W-1:0]  DAY_MS    = 33'sd86400000;
    localparam logic signed [WIDE_W-1:0]  PROC_MS   = 33'sd5;
    localparam logic signed [WIDE_W-1:0]  OFF_MAX   = 33'sd67108863;
    localparam logic signed [WIDE_W-1:0]  OFF_MIN   = -33'sd67108864;
    localparam logic signed [DELTA_W-1:0] MIN_RST   = 32'sh7fffffff;

    // Queue between front and back
    localparam int QUEUE_DEPTH_DEF = 2;

    // Event kinds on the input channel
    typedef enum logic [FUNC_W-1:0] {
        FN_START   = 2'd0,
        FN_REPLY   = 2'd1,
        FN_TIMEOUT = 2'd2,
        FN_IOERR   = 2'd3
    } func_t;

    // Measurement status
    typedef enum logic [STATUS_W-1:0] {
        ST_RUNNING  = 3'd0,
        ST_GOOD     = 3'd1,
        ST_HOSTDOWN = 3'd2,
        ST_NONSTD   = 3'd3,
        ST_ERROR    = 3'd4
    } status_t;

    // Classified operation handed from front to back
    typedef enum logic [2:0] {
        OP_START   = 3'd0,
        OP_TIMEOUT = 3'd1,
        OP_IOERR   = 3'd2,
        OP_IGNORE  = 3'd3,
        OP_REJECT  = 3'd4,
        OP_NONSTD  = 3'd5,
        OP_SAMPLE  = 3'd6
    } op_kind_t;

    typedef struct packed {
        op_kind_t                   kind;
        logic signed [DELTA_W-1:0]  d_out;
        logic signed [DELTA_W-1:0]  d_in;
    } op_t;

    // Configuration register file contents
    typedef struct packed {
        logic                 check_range;
        logic [MS_W-1:0]      round_trip_limit;
        logic [COUNT_W-1:0]   samples_needed;
        logic [COUNT_W-1:0]   retry_limit;
        logic [IDENT_W-1:0]   local_ident;
    } cfg_t;

    // One add or subtract of a day brings a delta towards +-12 h
    function automatic logic signed [WIDE_W-1:0] fold_day(input logic signed [WIDE_W-1:0] d);
        logic signed [WIDE_W-1:0] r;
        begin
            r = d;
            if (d < WRAP_LOW)
            begin
                r = d + DAY_MS;
            end
            else if (d > WRAP_HIGH)
            begin
                r = d - DAY_MS;
            end
            return r;
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/cofs_if.sv =====
// Channel interfaces: event input, result output and configuration write.
`default_nettype none

interface cofs_evt_if
    import cofs_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic [TYPE_W-1:0]   reply_type;
    logic [IDENT_W-1:0]  reply_ident;
    logic [MS_W-1:0]     send_time;
    logic [MS_W-1:0]     recv_time;
    logic [REMOTE_W-1:0] remote_time;

    modport source (
        output valid, func, reply_type, reply_ident, send_time, recv_time, remote_time,
        input  ready
    );
    modport sink (
        input  valid, func, reply_type, reply_ident, send_time, recv_time, remote_time,
        output ready
    );
endinterface

interface cofs_res_if
    import cofs_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic [STATUS_W-1:0]        status;
    logic                       done_res;
    logic signed [OFFSET_W-1:0] offset_ms;
    logic [COUNT_W-1:0]         samples_taken;

    modport source (
        output valid, status, done_res, offset_ms, samples_taken,
        input  ready
    );
    modport sink (
        input  valid, status, done_res, offset_ms, samples_taken,
        output ready
    );
endinterface

interface cofs_cfg_if
    import cofs_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/clock_offset_min_filter.sv =====
// Top level of the clock offset minimum filter: configuration registers and wiring.
//
//  channel  dir   handshake      carries
//  -------  ----  -------------  ---------------------------------------------------
//  evt      in    valid / ready  func, reply_type, reply_ident, send/recv/remote time
//  res      out   valid / ready  status, done_res, offset_ms, samples_taken
//  cfg      in    valid / ready  index, data (register write, ready always high)
//
//  One event per cycle sustained while results are taken; one result per event.
//  An event is classified and written into the queue on its transfer edge; when
//  popped it is applied to the state registers, and res.valid rises on that same
//  edge, so the result transfer comes after the queue and the result slot.
//  The front/back queue (QUEUE_DEPTH entries) absorbs result stalls; evt.ready
//  drops only when it is full. Reset restores the register defaults and clears
//  the measurement; no clearing pass is needed.
`default_nettype none

module clock_offset_min_filter
    import cofs_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire        clk,
    input  wire        rst_n,
    cofs_evt_if.sink   evt,
    cofs_res_if.source res,
    cofs_cfg_if.sink   cfg
);

    cfg_t cfg_reg;
    logic push;
    op_t  push_op;
    logic pop;
    logic q_valid;
    logic q_full;
    op_t  q_op;

    // Configuration register writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.check_range      <= CHECK_RANGE_RST;
            cfg_reg.round_trip_limit <= ROUND_TRIP_LIM_RST;
            cfg_reg.samples_needed   <= SAMPLES_NEEDED_RST;
            cfg_reg.retry_limit      <= RETRY_LIMIT_RST;
            cfg_reg.local_ident      <= LOCAL_IDENT_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_IDX_CHECK_RANGE:    cfg_reg.check_range      <= cfg.data[0];
                CFG_IDX_ROUND_TRIP_LIM: cfg_reg.round_trip_limit <= cfg.data[MS_W-1:0];
                CFG_IDX_SAMPLES_NEEDED: cfg_reg.samples_needed   <= cfg.data[COUNT_W-1:0];
                CFG_IDX_RETRY_LIMIT:    cfg_reg.retry_limit      <= cfg.data[COUNT_W-1:0];
                CFG_IDX_LOCAL_IDENT:    cfg_reg.local_ident      <= cfg.data[IDENT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Front end
    cofs_front u_front (
        .evt     (evt),
        .cfg     (cfg_reg),
        .q_full  (q_full),
        .push    (push),
        .push_op (push_op)
    );

    // Operation queue
    cofs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .q_valid (q_valid),
        .q_full  (q_full),
        .q_op    (q_op)
    );

    // Back end
    cofs_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_op    (q_op),
        .pop     (pop),
        .res     (res)
    );

endmodule

`default_nettype wire

// ===== rtl/cofs_front.sv =====
// Front end: accepts events and classifies them into operations for the back end.
`default_nettype none

module cofs_front
    import cofs_pkg::*;
(
    cofs_evt_if.sink evt,
    input  var cfg_t cfg,
    input  wire      q_full,
    output logic     push,
    output op_t      push_op
);

    logic                      match;
    logic signed [MS_W:0]      rtt;
    logic                      rtt_bad;
    logic signed [WIDE_W-1:0]  d_out_raw;
    logic signed [WIDE_W-1:0]  d_in_raw;
    logic signed [WIDE_W-1:0]  d_out_fold;
    logic signed [WIDE_W-1:0]  d_in_fold;

    // Handshake: take an event whenever the queue has room
    assign evt.ready = !q_full;
    assign push      = evt.valid && !q_full;

    // Reply checks and folded deltas
    always_comb
    begin
        match      = (evt.reply_type == TS_REPLY) && (evt.reply_ident == cfg.local_ident);
        rtt        = $signed({1'b0, evt.recv_time}) - $signed({1'b0, evt.send_time});
        rtt_bad    = rtt[MS_W] ||
                     (cfg.check_range && (rtt[MS_W-1:0] > cfg.round_trip_limit));
        d_out_raw  = $signed({1'b0, evt.remote_time})
                   - $signed({{(WIDE_W-MS_W){1'b0}}, evt.send_time});
        d_in_raw   = $signed({{(WIDE_W-MS_W){1'b0}}, evt.recv_time})
                   - $signed({1'b0, evt.remote_time});
        d_out_fold = fold_day(d_out_raw);
        d_in_fold  = fold_day(d_in_raw);
    end

    // Classification
    always_comb
    begin
        push_op.d_out = d_out_fold[DELTA_W-1:0];
        push_op.d_in  = d_in_fold[DELTA_W-1:0];
        unique case (func_t'(evt.func))
            FN_START:   push_op.kind = OP_START;
            FN_TIMEOUT: push_op.kind = OP_TIMEOUT;
            FN_IOERR:   push_op.kind = OP_IOERR;
            FN_REPLY:
            begin
                priority if (!match)
                begin
                    push_op.kind = OP_IGNORE;
                end
                else if (rtt_bad)
                begin
                    push_op.kind = OP_REJECT;
                end
                else if (evt.remote_time[REMOTE_W-1])
                begin
                    push_op.kind = OP_NONSTD;
                end
                else
                begin
                    push_op.kind = OP_SAMPLE;
                end
            end
            default:    push_op.kind = OP_IGNORE;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/cofs_queue.sv =====
// Short FIFO of classified operations between front and back.
`default_nettype none

module cofs_queue
    import cofs_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire     clk,
    input  wire     rst_n,
    input  wire     push,
    input  var op_t push_op,
    input  wire     pop,
    output logic    q_valid,
    output logic    q_full,
    output op_t     q_op
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    op_t              store [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign q_valid = (count_reg != '0);
    assign q_full  = (count_reg == FULL_CNT);
    assign q_op    = store[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store[wr_ptr_reg] <= push_op;
        end
    end

    // Checks
    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("queue fill count beyond depth");

    a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid)
        else $error("queue popped while empty");

endmodule

`default_nettype wire

// ===== rtl/cofs_back.sv =====
// Back end: applies operations to the measurement state and presents the result.
`default_nettype none

module cofs_back
    import cofs_pkg::*;
(
    input  wire      clk,
    input  wire      rst_n,
    input  var cfg_t cfg,
    input  wire      q_valid,
    input  var op_t  q_op,
    output logic     pop,
    cofs_res_if.source res
);

    status_t                    status_reg, status_next;
    logic signed [DELTA_W-1:0]  min_out_reg, min_out_next;
    logic signed [DELTA_W-1:0]  min_in_reg, min_in_next;
    logic [COUNT_W-1:0]         acc_cnt_reg, acc_cnt_next;
    logic [COUNT_W-1:0]         retry_cnt_reg, retry_cnt_next;
    logic signed [OFFSET_W-1:0] offset_reg, offset_next;
    logic                       res_valid_reg, res_valid_next;

    logic signed [WIDE_W-1:0]   diff;
    logic signed [WIDE_W-1:0]   half;
    logic signed [WIDE_W-1:0]   off_full;
    logic                       running;

    // A new operation is applied when the result slot is free or being taken
    assign pop     = q_valid && (!res_valid_reg || res.ready);
    assign running = (status_reg == ST_RUNNING);

    // Offset from the updated minima: halve toward zero, add processing time, saturate
    always_comb
    begin
        diff     = WIDE_W'(min_out_next) - WIDE_W'(min_in_next);
        half     = (diff + (diff[WIDE_W-1] ? WIDE_W'(1) : WIDE_W'(0))) >>> 1;
        off_full = half + PROC_MS;
        if (off_full > OFF_MAX)
        begin
            off_full = OFF_MAX;
        end
        else if (off_full < OFF_MIN)
        begin
            off_full = OFF_MIN;
        end
    end

    // State update
    always_comb
    begin
        status_next    = status_reg;
        min_out_next   = min_out_reg;
        min_in_next    = min_in_reg;
        acc_cnt_next   = acc_cnt_reg;
        retry_cnt_next = retry_cnt_reg;
        offset_next    = offset_reg;
        if (pop)
        begin
            if (q_op.kind == OP_START)
            begin
                status_next    = ST_RUNNING;
                min_out_next   = MIN_RST;
                min_in_next    = MIN_RST;
                acc_cnt_next   = '0;
                retry_cnt_next = '0;
                offset_next    = '0;
            end
            else if (running)
            begin
                unique case (q_op.kind)
                    OP_TIMEOUT:
                    begin
                        retry_cnt_next = retry_cnt_reg + 1'b1;
                        if (retry_cnt_next >= cfg.retry_limit)
                        begin
                            status_next = ST_HOSTDOWN;
                        end
                    end
                    OP_IOERR:
                    begin
                        status_next = ST_ERROR;
                    end
                    OP_REJECT:
                    begin
                        retry_cnt_next = '0;
                    end
                    OP_NONSTD:
                    begin
                        retry_cnt_next = '0;
                        status_next    = ST_NONSTD;
                    end
                    OP_SAMPLE:
                    begin
                        retry_cnt_next = '0;
                        if (q_op.d_out < min_out_reg)
                        begin
                            min_out_next = q_op.d_out;
                        end
                        if (q_op.d_in < min_in_reg)
                        begin
                            min_in_next = q_op.d_in;
                        end
                        acc_cnt_next = acc_cnt_reg + 1'b1;
                        if (acc_cnt_next >= cfg.samples_needed)
                        begin
                            offset_next = off_full[OFFSET_W-1:0];
                            status_next = ST_GOOD;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Result slot valid
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (pop)
        begin
            res_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg    <= ST_RUNNING;
            min_out_reg   <= MIN_RST;
            min_in_reg    <= MIN_RST;
            acc_cnt_reg   <= '0;
            retry_cnt_reg <= '0;
            offset_reg    <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            status_reg    <= status_next;
            min_out_reg   <= min_out_next;
            min_in_reg    <= min_in_next;
            acc_cnt_reg   <= acc_cnt_next;
            retry_cnt_reg <= retry_cnt_next;
            offset_reg    <= offset_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // State only changes on pop, so the state registers are the result payload
    assign res.valid         = res_valid_reg;
    assign res.status        = status_reg;
    assign res.done_res      = !running;
    assign res.offset_ms     = (status_reg == ST_GOOD) ? offset_reg : '0;
    assign res.samples_taken = acc_cnt_reg;

    // Checks
    a_frozen_when_done: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !running && (q_op.kind != OP_START)
        |=> $stable(min_out_reg) && $stable(min_in_reg) && $stable(status_reg))
        else $error("finished measurement changed without a start");

    a_sample_counts: assert property (@(posedge clk) disable iff (!rst_n)
        pop && running && (q_op.kind == OP_SAMPLE)
        |=> acc_cnt_reg == COUNT_W'($past(acc_cnt_reg) + 1'b1))
        else $error("accepted sample not counted");

    a_payload_held: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !res.ready |=> $stable(status_reg) && $stable(acc_cnt_reg))
        else $error("state moved under a stalled result");

endmodule

`default_nettype wire

// ===== test/clock_offset_min_filter_tb.sv =====
// Self-checking testbench for the clock offset minimum filter: directed and random event streams.
module clock_offset_min_filter_tb
    import cofs_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint MS_PER_DAY    = 86400000;
    localparam longint HALF_DAY_HI   = 43199999;
    localparam longint HALF_DAY_LO   = -43200000;
    localparam longint TURNAROUND_MS = 5;
    localparam longint OFFSET_CEIL   = 67108863;
    localparam longint OFFSET_FLOOR  = -67108864;
    localparam longint LAST_MS       = 86399999;
    localparam longint MS_FIELD_MAX  = 134217727;
    localparam int     MIN_RESET     = 32'h7fffffff;

    localparam int PHASES        = 8;
    localparam int PHASE_QUOTA   = 240;
    localparam int HOLD_CYCLES   = 64;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int REPORT_LIMIT  = 10;

    // One event on the input channel
    typedef struct packed {
        func_t               func;
        logic [TYPE_W-1:0]   reply_type;
        logic [IDENT_W-1:0]  reply_ident;
        logic [MS_W-1:0]     send_time;
        logic [MS_W-1:0]     recv_time;
        logic [REMOTE_W-1:0] remote_time;
    } ts_event_t;

    // Measurement state as reported on the result channel
    typedef struct packed {
        status_t             status;
        logic                done;
        logic [OFFSET_W-1:0] offset;
        logic [COUNT_W-1:0]  samples;
    } measurement_view_t;

    // One register setting of a phase
    typedef struct packed {
        logic                check;
        logic [MS_W-1:0]     limit;
        logic [COUNT_W-1:0]  needed;
        logic [COUNT_W-1:0]  retries;
        logic [IDENT_W-1:0]  ident;
    } setting_t;

    typedef enum int {
        RP_GOOD,
        RP_OVER,
        RP_NEGATIVE,
        RP_NONSTD,
        RP_WIDE,
        RP_FOREIGN
    } reply_flavour_t;

    // Tracks the measurement and holds the views still owed by the block
    class offset_scoreboard;
        cfg_t                 regs;
        int                   min_out;
        int                   min_in;
        logic [COUNT_W-1:0]   n_accepted;
        logic [COUNT_W-1:0]   n_retries;
        status_t              run_state;
        int                   offset_val;
        measurement_view_t    owed_views[$];
        int                   n_events;
        int                   n_checked;
        int                   n_mismatch;
        int                   n_ended[status_t];

        function new();
            regs.check_range      = 1'b1;
            regs.round_trip_limit = 27'd20;
            regs.samples_needed   = 8'd5;
            regs.retry_limit      = 8'd10;
            regs.local_ident      = 16'd0;
            clear_measurement();
        endfunction

        function void clear_measurement();
            min_out    = MIN_RESET;
            min_in     = MIN_RESET;
            n_accepted = '0;
            n_retries  = '0;
            run_state  = ST_RUNNING;
            offset_val = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_IDX_CHECK_RANGE:    regs.check_range      = value[0];
                CFG_IDX_ROUND_TRIP_LIM: regs.round_trip_limit = value[MS_W-1:0];
                CFG_IDX_SAMPLES_NEEDED: regs.samples_needed   = value[COUNT_W-1:0];
                CFG_IDX_RETRY_LIMIT:    regs.retry_limit      = value[COUNT_W-1:0];
                CFG_IDX_LOCAL_IDENT:    regs.local_ident      = value[IDENT_W-1:0];
                default: ;
            endcase
        endfunction

        // One add or subtract of a day brings a delta into the half-day window
        function longint to_half_day(longint d);
            if (d < HALF_DAY_LO)
                return d + MS_PER_DAY;
            if (d > HALF_DAY_HI)
                return d - MS_PER_DAY;
            return d;
        endfunction

        function void take_sample(ts_event_t e);
            longint snd;
            longint rcv;
            longint rem;
            longint rtt;
            longint d_out;
            longint d_in;
            longint est;
            longint lim;
            if (e.reply_type != TS_REPLY || e.reply_ident != regs.local_ident)
                return;
            n_retries = '0;
            snd = e.send_time;
            rcv = e.recv_time;
            rem = e.remote_time;
            lim = regs.round_trip_limit;
            rtt = rcv - snd;
            if (rtt < 0 || (regs.check_range && rtt > lim))
                return;
            if (e.remote_time[REMOTE_W-1])
            begin
                run_state = ST_NONSTD;
                return;
            end
            d_out = to_half_day(rem - snd);
            d_in  = to_half_day(rcv - rem);
            if (d_out < min_out)
                min_out = int'(d_out);
            if (d_in < min_in)
                min_in = int'(d_in);
            n_accepted = n_accepted + 8'd1;
            if (n_accepted >= regs.samples_needed)
            begin
                // truncating division, then the fixed turnaround allowance
                est = (longint'(min_out) - longint'(min_in)) / 2 + TURNAROUND_MS;
                if (est > OFFSET_CEIL)
                    est = OFFSET_CEIL;
                if (est < OFFSET_FLOOR)
                    est = OFFSET_FLOOR;
                offset_val = int'(est);
                run_state  = ST_GOOD;
            end
        endfunction

        function void note_event(ts_event_t e);
            measurement_view_t v;
            n_events++;
            if (e.func == FN_START)
            begin
                clear_measurement();
            end
            else if (run_state == ST_RUNNING)
            begin
                case (e.func)
                    FN_REPLY: take_sample(e);
                    FN_TIMEOUT:
                    begin
                        n_retries = n_retries + 8'd1;
                        if (n_retries >= regs.retry_limit)
                            run_state = ST_HOSTDOWN;
                    end
                    default: run_state = ST_ERROR;
                endcase
                if (run_state != ST_RUNNING)
                    n_ended[run_state]++;
            end
            v.status  = run_state;
            v.done    = (run_state != ST_RUNNING);
            v.offset  = (run_state == ST_GOOD) ? offset_val[OFFSET_W-1:0] : '0;
            v.samples = n_accepted;
            owed_views.push_back(v);
        endfunction

        function void check_result(logic [STATUS_W-1:0] st, logic dn,
                                   logic [OFFSET_W-1:0] off, logic [COUNT_W-1:0] cnt);
            measurement_view_t want;
            if (owed_views.size() == 0)
            begin
                n_mismatch++;
                if (n_mismatch <= REPORT_LIMIT)
                    $display("%0t: result with none outstanding: status %0d done %0b",
                             $realtime, st, dn,
                             " offset %0d samples %0d", $signed(off), cnt);
                return;
            end
            want = owed_views.pop_front();
            n_checked++;
            if (st !== want.status || dn !== want.done || off !== want.offset ||
                cnt !== want.samples)
            begin
                n_mismatch++;
                if (n_mismatch <= REPORT_LIMIT)
                    $display("%0t: mismatch (want/got) status %0d/%0d done %0b/%0b",
                             $realtime, want.status, st, want.done, dn,
                             " offset %0d/%0d samples %0d/%0d",
                             $signed(want.offset), $signed(off), want.samples, cnt);
            end
        endfunction

        function bit finished();
            return run_state != ST_RUNNING;
        endfunction

        function int pending();
            return owed_views.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    cofs_evt_if evt_ch();
    cofs_res_if res_ch();
    cofs_cfg_if cfg_ch();

    clock_offset_min_filter dut (
        .clk   (clk),
        .rst_n (rst_n),
        .evt   (evt_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    offset_scoreboard book;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_token     = 0;

    always #6 clk = ~clk;

    // Sample every transfer at the rising edge; inputs before results
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_ch.valid && cfg_ch.ready)
                book.write_reg(cfg_ch.index, cfg_ch.data);
            if (evt_ch.valid && evt_ch.ready)
                book.note_event({func_t'(evt_ch.func), evt_ch.reply_type, evt_ch.reply_ident,
                                 evt_ch.send_time, evt_ch.recv_time, evt_ch.remote_time});
            if (res_ch.valid && res_ch.ready)
                book.check_result(res_ch.status, res_ch.done_res, res_ch.offset_ms,
                                  res_ch.samples_taken);
        end
    end

    // Result receiver: random stalls, plus a long hold-off on request
    initial
    begin
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_token != hold_seen)
            begin
                hold_seen = hold_token;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready = 1'b0;
            end
            else
            begin
                res_ch.ready = ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Watchdog
    initial
    begin
        #5ms;
        $display("tb: failure");
        $finish;
    end

    function automatic ts_event_t ev(func_t f, logic [TYPE_W-1:0] t, logic [IDENT_W-1:0] id,
                                     logic [MS_W-1:0] snd, logic [MS_W-1:0] rcv,
                                     logic [REMOTE_W-1:0] rem);
        ts_event_t e;
        e.func        = f;
        e.reply_type  = t;
        e.reply_ident = id;
        e.send_time   = snd;
        e.recv_time   = rcv;
        e.remote_time = rem;
        return e;
    endfunction

    // Event of a given kind with random content in every field
    function automatic ts_event_t make_bare(func_t f);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        a = $urandom();
        b = $urandom();
        c = $urandom();
        d = $urandom();
        return ev(f, a[TYPE_W-1:0], a[31:16], b[MS_W-1:0], c[MS_W-1:0], d);
    endfunction

    // Timestamp reply shaped after the current registers
    function automatic ts_event_t make_reply(reply_flavour_t flavour);
        ts_event_t e;
        longint snd;
        longint rcv;
        longint rtt;
        longint span;
        longint skew;
        longint rem;
        logic [7:0] other_type;
        span = book.regs.check_range ? longint'(book.regs.round_trip_limit) : 3000;
        if (span > 3000)
            span = 3000;
        if ($urandom_range(19) == 0)
            snd = $urandom_range(int'(MS_FIELD_MAX - 6000), int'(MS_PER_DAY));
        else
            snd = $urandom_range(int'(LAST_MS), 0);
        rtt = $urandom_range(int'(span), 0);
        if (flavour == RP_OVER)
        begin
            rtt = longint'(book.regs.round_trip_limit) + 1 + $urandom_range(500);
            if (snd + rtt > MS_FIELD_MAX)
                snd = 0;
        end
        rcv = snd + rtt;
        if (flavour == RP_NEGATIVE)
        begin
            if (snd == 0)
                snd = 1;
            rcv = snd - $urandom_range((snd < 5000) ? int'(snd) : 5000, 1);
        end
        // mostly within an hour of local time, sometimes anywhere in the day
        if ($urandom_range(9) == 0)
            skew = $urandom_range(int'(LAST_MS), 0);
        else
            skew = longint'($urandom_range(7200000)) - 3600000;
        rem = (snd + rtt / 2 + skew) % MS_PER_DAY;
        if (rem < 0)
            rem = rem + MS_PER_DAY;
        if (flavour == RP_NONSTD)
            rem = $urandom() | 32'h80000000;
        if (flavour == RP_WIDE)
            rem = $urandom_range(32'h7fffffff, int'(MS_PER_DAY));
        e = ev(FN_REPLY, TS_REPLY, book.regs.local_ident, snd[MS_W-1:0], rcv[MS_W-1:0],
               rem[REMOTE_W-1:0]);
        if (flavour == RP_FOREIGN)
        begin
            if ($urandom_range(1) == 0)
            begin
                other_type = $urandom_range(255);
                if (other_type == TS_REPLY)
                    other_type = other_type + 8'd1;
                e.reply_type = other_type;
            end
            else
            begin
                e.reply_ident = book.regs.local_ident ^ 16'($urandom_range(65535, 1));
            end
        end
        return e;
    endfunction

    // Offer one event and hold it until the block takes it
    task automatic push_event(ts_event_t e);
        while ($urandom_range(99) < send_idle_pct)
        begin
            evt_ch.valid = 1'b0;
            @(negedge clk);
        end
        evt_ch.func        = e.func;
        evt_ch.reply_type  = e.reply_type;
        evt_ch.reply_ident = e.reply_ident;
        evt_ch.send_time   = e.send_time;
        evt_ch.recv_time   = e.recv_time;
        evt_ch.remote_time = e.remote_time;
        evt_ch.valid       = 1'b1;
        @(posedge clk);
        while (!evt_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Push it, and count it unless the block would only ignore it
    task automatic offer(ts_event_t e, inout int taken);
        bit counts;
        counts = !book.finished() || e.func == FN_START;
        push_event(e);
        if (counts)
            taken++;
    endtask

    task automatic wait_idle();
        int spin;
        spin = 0;
        evt_ch.valid = 1'b0;
        while (book.pending() != 0 && spin < DRAIN_LIMIT)
        begin
            @(negedge clk);
            spin++;
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_ch.index = idx;
        cfg_ch.data  = value;
        cfg_ch.valid = 1'b1;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic apply_settings(setting_t s);
        wait_idle();
        write_reg(CFG_IDX_CHECK_RANGE, 32'(s.check));
        write_reg(CFG_IDX_ROUND_TRIP_LIM, 32'(s.limit));
        write_reg(CFG_IDX_SAMPLES_NEEDED, 32'(s.needed));
        write_reg(CFG_IDX_RETRY_LIMIT, 32'(s.retries));
        write_reg(CFG_IDX_LOCAL_IDENT, 32'(s.ident));
        cfg_ch.valid = 1'b0;
    endtask

    // Mostly well-formed measurements with random content, some noise
    task automatic run_random(int quota);
        int taken;
        int pick;
        int burst;
        taken = 0;
        while (taken < quota)
        begin
            pick = $urandom_range(99);
            if (book.finished())
            begin
                if (pick < 85)
                    offer(make_bare(FN_START), taken);
                else
                    offer(make_bare(func_t'($urandom_range(3, 1))), taken);
            end
            else if (pick < 55)
                offer(make_reply(RP_GOOD), taken);
            else if (pick < 60)
                offer(make_reply(RP_OVER), taken);
            else if (pick < 64)
                offer(make_reply(RP_NEGATIVE), taken);
            else if (pick < 70)
                offer(make_reply(RP_FOREIGN), taken);
            else if (pick < 80)
                offer(make_bare(FN_TIMEOUT), taken);
            else if (pick < 82)
            begin
                // run of timeouts long enough to reach a small retry limit
                burst = int'(book.regs.retry_limit) + 1;
                if (burst > 12)
                    burst = 12;
                repeat (burst) offer(make_bare(FN_TIMEOUT), taken);
            end
            else if (pick < 84)
                offer(make_bare(FN_IOERR), taken);
            else if (pick < 87)
                offer(make_reply(RP_NONSTD), taken);
            else if (pick < 90)
                offer(make_reply(RP_WIDE), taken);
            else if (pick < 95)
                offer(make_bare(func_t'($urandom_range(3))), taken);
            else
                offer(make_bare(FN_START), taken);
        end
    endtask

    // Main sequence
    initial
    begin
        setting_t plan [PHASES];
        int idle_send [4];
        int idle_recv [4];
        int leftover;

        book = new();
        idle_send = '{0, 67, 0, 13};
        idle_recv = '{0, 0, 67, 13};

        rst_n              = 1'b0;
        evt_ch.valid       = 1'b0;
        evt_ch.func        = FN_START;
        evt_ch.reply_type  = '0;
        evt_ch.reply_ident = '0;
        evt_ch.send_time   = '0;
        evt_ch.recv_time   = '0;
        evt_ch.remote_time = '0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = CFG_IDX_CHECK_RANGE;
        cfg_ch.data        = '0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // Directed part under the reset register values
        push_event(ev(FN_REPLY, TS_REPLY, 16'd0, 27'd1000, 27'd1005, 32'd1003));
        push_event(ev(FN_TIMEOUT, 8'd0, 16'd0, 27'd0, 27'd0, 32'd0));
        push_event(ev(FN_START, 8'hff, 16'hffff, 27'h7ffffff, 27'h7ffffff, 32'hffffffff));
        push_event(ev(FN_REPLY, TS_REPLY, 16'd0, 27'd0, 27'd20, 32'd0));
        push_event(ev(FN_REPLY, TS_REPLY, 16'd0, 27'd86399999, 27'd86399999, 32'd0));
        push_event(ev(FN_REPLY, TS_REPLY, 16'd0, 27'd100, 27'd121, 32'd110));
        push_event(ev(FN_REPLY, TS_REPLY, 16'd0, 27'd100, 27'd99, 32'd99));
        push_event(ev(FN_REPLY, 8'd13, 16'd0, 27'd10, 27'd12, 32'd11));
        push_event(ev(FN_REPLY, TS_REPLY, 16'hffff, 27'd10, 27'd12, 32'd11));
        push_event(ev(FN_REPLY, 8'hff, 16'hffff, 27'h7ffffff, 27'h7ffffff, 32'hffffffff));
        push_event(ev(FN_TIMEOUT, 8'd0, 16'd0, 27'd0, 27'd0, 32'd0));
        push_event(ev(FN_REPLY, TS_REPLY, 16'd0, 27'd5000, 27'd5004, 32'd3605000));
        push_event(ev(FN_REPLY, TS_REPLY, 16'd0, 27'd86399990, 27'd86399999, 32'd5));
        push_event(ev(FN_REPLY, TS_REPLY, 16'd0, 27'd0, 27'd0, 32'd86399999));
        push_event(ev(FN_TIMEOUT, 8'd0, 16'd0, 27'd0, 27'd0, 32'd0));
        push_event(ev(FN_IOERR, 8'd0, 16'd0, 27'd0, 27'd0, 32'd0));
        push_event(ev(FN_START, 8'd0, 16'd0, 27'd0, 27'd0, 32'd0));
        push_event(ev(FN_IOERR, 8'd0, 16'd0, 27'd0, 27'd0, 32'd0));
        push_event(ev(FN_REPLY, TS_REPLY, 16'd0, 27'd1, 27'd2, 32'd1));
        push_event(ev(FN_START, 8'd0, 16'd0, 27'd0, 27'd0, 32'd0));
        push_event(ev(FN_REPLY, TS_REPLY, 16'd0, 27'd7, 27'd7, 32'h80000000));
        push_event(ev(FN_START, 8'd0, 16'd0, 27'd0, 27'd0, 32'd0));
        push_event(ev(FN_REPLY, TS_REPLY, 16'd0, 27'h7ffffff, 27'h7ffffff, 32'h7fffffff));

        // Register settings of the random phases, extremes included
        plan[0] = '{1'b1, 27'd20, 8'd5, 8'd10, 16'd0};
        plan[1] = '{1'b0, 27'd0, 8'd1, 8'd1, 16'hffff};
        plan[2] = '{1'b1, 27'd86399999, 8'd255, 8'd255, 16'($urandom())};
        plan[3] = '{1'b1, 27'd0, 8'd3, 8'd4, 16'($urandom())};
        plan[4] = '{1'b1, 27'($urandom_range(2000, 1)), 8'($urandom_range(8, 2)),
                    8'($urandom_range(12, 2)), 16'($urandom())};
        plan[5] = '{1'b0, 27'd50, 8'd0, 8'd0, 16'($urandom())};
        plan[6] = '{1'b1, 27'd100, 8'd6, 8'd8, 16'($urandom())};
        plan[7] = '{1'b1, 27'd100, 8'd1, 8'd1, plan[6].ident};

        for (int p = 0; p < PHASES; p++)
        begin
            apply_settings(plan[p]);
            send_idle_pct  = idle_send[p % 4];
            recv_stall_pct = idle_recv[p % 4];
            if (p == 1)
            begin
                // saturated offset, then host down on the first timeout
                push_event(make_bare(FN_START));
                push_event(ev(FN_REPLY, TS_REPLY, 16'hffff, 27'd0, 27'd0, 32'h7fffffff));
                push_event(make_bare(FN_START));
                push_event(make_bare(FN_TIMEOUT));
            end
            if (p == 4)
                hold_token++;
            if (p == 5)
            begin
                // zero limits finish on the first timeout or sample
                push_event(make_bare(FN_START));
                push_event(make_bare(FN_TIMEOUT));
                push_event(make_bare(FN_START));
                push_event(make_reply(RP_GOOD));
            end
            run_random(PHASE_QUOTA);
            if (p == 6)
            begin
                // leave a measurement running; the next phase lowers both limits
                push_event(make_bare(FN_START));
                repeat (3) push_event(make_reply(RP_GOOD));
                repeat (2) push_event(make_bare(FN_TIMEOUT));
            end
        end

        wait_idle();
        leftover = book.pending();
        if (leftover != 0)
            $display("%0d results never arrived", leftover);
        $display("covered %0d events over %0d register settings, %0d results checked",
                 book.n_events, PHASES + 1, book.n_checked);
        $display("measurements ended: good %0d, host down %0d,",
                 book.n_ended[ST_GOOD], book.n_ended[ST_HOSTDOWN],
                 " nonstandard %0d, error %0d; mismatches %0d",
                 book.n_ended[ST_NONSTD], book.n_ended[ST_ERROR], book.n_mismatch);
        if (book.n_mismatch == 0 && leftover == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
